// ===== rtl/core/csq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package csq_pkg;
    localparam int CSQ_MAX_LEVEL = 6;
    localparam int CSQ_FRAC_BITS = 14;
    localparam int CSQ_QUAD_W = 15;
    localparam int CSQ_LVL_W = 3;
    localparam int CSQ_COORD_W = 16;

    // corner sign bits: 1 means negative, order x, y, z
    function automatic logic [2:0] corner_neg(input logic [2:0] idx);
        logic [2:0] r;
        begin
            case (idx)
                3'd0: r = 3'b110;
                3'd1: r = 3'b100;
                3'd2: r = 3'b000;
                3'd3: r = 3'b010;
                3'd4: r = 3'b111;
                3'd5: r = 3'b101;
                3'd6: r = 3'b001;
                default: r = 3'b011;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] face_corner(input logic [2:0] face, input logic [1:0] k);
        logic [11:0] row;
        begin
            case (face)
                3'd0: row = {3'd2, 3'd3, 3'd0, 3'd1};
                3'd1: row = {3'd6, 3'd7, 3'd3, 3'd2};
                3'd2: row = {3'd7, 3'd4, 3'd0, 3'd3};
                3'd3: row = {3'd2, 3'd1, 3'd5, 3'd6};
                3'd4: row = {3'd7, 3'd6, 3'd5, 3'd4};
                default: row = {3'd1, 3'd0, 3'd4, 3'd5};
            endcase
            return row[k*3 +: 3];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/csq_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Iterative vector normalizer: one sum-of-squares multiply a cycle,
// then a bit-serial square root, then three bit-serial restoring divides.
// Steps from start to done: capture, three squares, the root steps, three
// divides, done.
module csq_norm #(
    parameter int FRAC = csq_pkg::CSQ_FRAC_BITS,
    parameter int IW   = csq_pkg::CSQ_FRAC_BITS + 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire signed [IW-1:0] i_x,
    input  wire signed [IW-1:0] i_y,
    input  wire signed [IW-1:0] i_z,
    output logic             o_done,
    output logic signed [FRAC+1:0] o_x,
    output logic signed [FRAC+1:0] o_y,
    output logic signed [FRAC+1:0] o_z
);
    import csq_pkg::*;
    localparam int SW = 2*IW + 2;           // sum of three squares
    localparam int RW = IW + 1;             // square root
    localparam int OW = FRAC + 2;           // quotient and output
    localparam int NW = IW + FRAC + 2;      // numerator width (m << F+1) + len
    localparam int DW = RW + 2;             // partial remainder

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SQ = 5'b00010, S_ROOT = 5'b00100,
        S_DIV = 5'b01000, S_FIN = 5'b10000
    } t_state;

    t_state r_state;
    logic [1:0] r_comp;
    logic [SW-1:0] r_s;
    logic [RW-1:0] r_root;
    logic [SW-1:0] r_rem;
    logic [5:0] r_cnt;
    logic [IW-1:0] r_mag [3];
    logic [2:0] r_neg;
    logic [OW-1:0] r_num;                   // low numerator bits still to shift in
    logic [DW-1:0] r_dr;
    logic [OW-1:0] r_q;
    logic [OW-1:0] r_res [3];

    logic [IW-1:0] w_m;
    logic [2*IW-1:0] w_sq;
    logic [SW-1:0] w_trial, w_rsh;
    logic [NW-1:0] w_nld;
    logic [DW-1:0] w_den, w_drs;
    logic w_ge;
    logic [OW-1:0] w_qn, w_qs;

    assign w_m  = r_mag[r_comp];
    assign w_sq = w_m * w_m;
    // restoring sqrt step on a pair of bits
    assign w_rsh = {r_rem[SW-3:0], r_s[SW-1 -: 2]};
    assign w_trial = {{(SW-RW-2){1'b0}}, r_root, 2'b01};
    // rounded divide: ((m << F+1) + len) / (2 * len)
    assign w_nld = NW'({w_m, (FRAC+1)'(0)}) + NW'(r_root);
    assign w_den = {1'b0, r_root, 1'b0};
    assign w_drs = {r_dr[DW-2:0], r_num[OW-1]};
    assign w_ge = (w_drs >= w_den);
    assign w_qn = {r_q[OW-2:0], w_ge};
    assign w_qs = (w_qn > OW'(1 << FRAC)) ? OW'(1 << FRAC) : w_qn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) r_state <= S_SQ;
                S_SQ: if (r_comp == 2'd2) r_state <= S_ROOT;
                S_ROOT: if (r_cnt == 6'(SW/2 - 1)) r_state <= S_DIV;
                S_DIV: if (r_cnt == 6'(OW) && r_comp == 2'd2) r_state <= S_FIN;
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_mag[0] <= i_x[IW-1] ? IW'(-i_x) : i_x;
                r_mag[1] <= i_y[IW-1] ? IW'(-i_y) : i_y;
                r_mag[2] <= i_z[IW-1] ? IW'(-i_z) : i_z;
                r_neg <= {i_z[IW-1], i_y[IW-1], i_x[IW-1]};
                r_comp <= '0;
                r_s <= '0;
            end
            S_SQ: begin
                r_s <= r_s + SW'(w_sq);
                r_comp <= (r_comp == 2'd2) ? 2'd0 : r_comp + 2'd1;
                r_rem <= '0;
                r_root <= '0;
                r_cnt <= '0;
            end
            S_ROOT: begin
                r_s <= {r_s[SW-3:0], 2'b00};
                if (w_rsh >= w_trial) begin
                    r_rem <= w_rsh - w_trial;
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(SW/2 - 1))
                    r_cnt <= '0;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    // load the high numerator bits, keep the low ones to shift in
                    r_dr <= DW'(w_nld[NW-1:OW]);
                    r_num <= w_nld[OW-1:0];
                    r_q <= '0;
                    r_cnt <= 6'd1;
                end else begin
                    r_dr <= w_ge ? (w_drs - w_den) : w_drs;
                    r_num <= {r_num[OW-2:0], 1'b0};
                    r_q <= w_qn;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(OW)) begin
                        r_res[r_comp] <= w_qs;
                        r_cnt <= '0;
                        if (r_comp != 2'd2)
                            r_comp <= r_comp + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == S_FIN);
    always_comb begin
        o_x = (r_root == '0) ? '0 : (r_neg[0] ? -$signed(r_res[0]) : $signed(r_res[0]));
        o_y = (r_root == '0) ? '0 : (r_neg[1] ? -$signed(r_res[1]) : $signed(r_res[1]));
        o_z = (r_root == '0) ? '0 : (r_neg[2] ? -$signed(r_res[2]) : $signed(r_res[2]));
    end
endmodule
`default_nettype wire

// ===== rtl/core/cube_sphere_quad_vertex_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                                         | handshake
// config    | i_cfg_we, i_cfg_data[2:0]                     | write when we high
// quad in   | i_start, i_quad_number[14:0], o_busy          | start & !busy
// vertex out| o_valid, o_pos_*, o_norm_*, o_tex_u/v, o_last | one cycle each
// An item runs 8 + 5*level normalizations (4 at level zero), each on the
// one shared normalizer (squares, root, three serial divides), plus an
// S_NEXT step per level and the six output vertices.
// Busy stays high the whole time.
// Reset is synchronous, active low; clears control, level reads 0.
// Six vertices leave on consecutive cycles; the receiver cannot stall.
module cube_sphere_quad_vertex_gen #(
    parameter int MAX_LEVEL = csq_pkg::CSQ_MAX_LEVEL
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [csq_pkg::CSQ_LVL_W-1:0] i_cfg_data,
    input  wire        i_start,
    input  wire [csq_pkg::CSQ_QUAD_W-1:0] i_quad_number,
    output logic       o_busy,
    output logic       o_valid,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic       o_tex_u,
    output logic       o_tex_v,
    output logic       o_last_vertex
);
    import csq_pkg::*;
    localparam int F = CSQ_FRAC_BITS;
    localparam int IW = F + 4;
    localparam int CW = F + 2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_CORN = 7'b0000010, S_MID = 7'b0000100,
        S_NWAIT = 7'b0001000, S_VNORM = 7'b0010000, S_EMIT = 7'b0100000,
        S_NEXT = 7'b1000000
    } t_state;

    t_state r_state;
    logic [CSQ_LVL_W-1:0] r_cfg, r_lvl;
    logic [CSQ_QUAD_W-1:0] r_q;
    logic [2:0] r_face;
    logic signed [CW-1:0] r_v [4][3];   // quad a..d
    logic signed [CW-1:0] r_n [4][3];   // normals of corners
    logic signed [CW-1:0] r_m [5][3];   // mab, mbc, mcd, mda, ctr
    logic [2:0] r_k;                    // job index
    logic [2:0] r_vi;                   // emitted vertex
    logic r_nstart;

    logic signed [IW-1:0] w_ix, w_iy, w_iz;
    logic w_done;
    logic signed [CW-1:0] w_ox, w_oy, w_oz;
    logic [CSQ_LVL_W-1:0] w_lvl;
    logic [CSQ_QUAD_W-1:0] w_qsh;
    logic w_face_ok;
    logic [2:0] w_face;
    logic [1:0] w_dig;
    logic [2:0] w_cn;
    logic [1:0] w_pa, w_pb, w_ei;

    assign w_lvl = (i_cfg_data > CSQ_LVL_W'(MAX_LEVEL)) ? CSQ_LVL_W'(MAX_LEVEL) : i_cfg_data;
    // face number at full width, so any value above five is dropped
    assign w_qsh = i_quad_number >> (2*r_cfg);
    assign w_face = w_qsh[2:0];
    assign w_face_ok = (w_qsh <= CSQ_QUAD_W'(5));
    assign w_dig = 2'(r_q >> (2*(r_lvl - 3'd1)));
    assign w_cn = corner_neg(face_corner(r_face, r_k[1:0]));

    // midpoint job k: 0 ab, 1 bc, 2 cd, 3 da, 4 ac
    always_comb begin
        case (r_k)
            3'd0: begin w_pa = 2'd0; w_pb = 2'd1; end
            3'd1: begin w_pa = 2'd1; w_pb = 2'd2; end
            3'd2: begin w_pa = 2'd2; w_pb = 2'd3; end
            3'd3: begin w_pa = 2'd3; w_pb = 2'd0; end
            default: begin w_pa = 2'd0; w_pb = 2'd2; end
        endcase
        case (r_vi) inside
            3'd0, 3'd3: w_ei = 2'd0;
            3'd1: w_ei = 2'd1;
            3'd2, 3'd4: w_ei = 2'd2;
            default: w_ei = 2'd3;
        endcase
    end

    always_comb begin
        if (r_state == S_CORN) begin
            w_ix = w_cn[2] ? -IW'(1 << (F-1)) : IW'(1 << (F-1));
            w_iy = w_cn[1] ? -IW'(1 << (F-1)) : IW'(1 << (F-1));
            w_iz = w_cn[0] ? -IW'(1 << (F-1)) : IW'(1 << (F-1));
        end else if (r_state == S_VNORM) begin
            w_ix = IW'(r_v[r_k[1:0]][0]);
            w_iy = IW'(r_v[r_k[1:0]][1]);
            w_iz = IW'(r_v[r_k[1:0]][2]);
        end else begin
            w_ix = IW'(r_v[w_pa][0]) + IW'(r_v[w_pb][0]);
            w_iy = IW'(r_v[w_pa][1]) + IW'(r_v[w_pb][1]);
            w_iz = IW'(r_v[w_pa][2]) + IW'(r_v[w_pb][2]);
        end
    end

    csq_norm #(.FRAC(F), .IW(IW)) u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_nstart),
        .i_x(w_ix), .i_y(w_iy), .i_z(w_iz), .o_done(w_done),
        .o_x(w_ox), .o_y(w_oy), .o_z(w_oz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= w_lvl;
        end
    end

    // sequencer: corners, per-level midpoints, per-vertex normals, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nstart <= 1'b0;
        end else begin
            r_nstart <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start && w_face_ok) begin
                    r_q <= i_quad_number;
                    r_lvl <= r_cfg;
                    r_face <= w_face;
                    r_k <= '0;
                    r_state <= S_CORN;
                    r_nstart <= (r_cfg != '0);
                end
                S_CORN: begin
                    if (r_lvl == '0) begin
                        // raw cube corners, no normalization
                        r_v[r_k[1:0]][0] <= w_cn[2] ? -CW'(1 << (F-1)) : CW'(1 << (F-1));
                        r_v[r_k[1:0]][1] <= w_cn[1] ? -CW'(1 << (F-1)) : CW'(1 << (F-1));
                        r_v[r_k[1:0]][2] <= w_cn[0] ? -CW'(1 << (F-1)) : CW'(1 << (F-1));
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd3) begin
                            r_k <= '0; r_state <= S_VNORM; r_nstart <= 1'b1;
                        end
                    end else if (w_done) begin
                        r_v[r_k[1:0]][0] <= w_ox;
                        r_v[r_k[1:0]][1] <= w_oy;
                        r_v[r_k[1:0]][2] <= w_oz;
                        r_k <= r_k + 3'd1;
                        r_nstart <= 1'b1;
                        if (r_k == 3'd3) begin
                            r_k <= '0; r_state <= S_MID;
                        end
                    end
                end
                S_MID: if (w_done) begin
                    r_m[r_k][0] <= w_ox; r_m[r_k][1] <= w_oy; r_m[r_k][2] <= w_oz;
                    r_k <= r_k + 3'd1;
                    r_nstart <= 1'b1;
                    if (r_k == 3'd4) begin
                        r_k <= '0;
                        r_state <= S_NEXT;
                        r_nstart <= 1'b0;
                    end
                end
                S_NEXT: begin
                    case (w_dig)
                        2'd0: begin r_v[1] <= r_m[0]; r_v[2] <= r_m[4];
                            r_v[3] <= r_m[3]; end
                        2'd1: begin r_v[0] <= r_m[0]; r_v[2] <= r_m[1];
                            r_v[3] <= r_m[4]; end
                        2'd2: begin r_v[0] <= r_m[4]; r_v[1] <= r_m[1];
                            r_v[3] <= r_m[2]; end
                        default: begin r_v[0] <= r_m[3]; r_v[1] <= r_m[4];
                            r_v[2] <= r_m[2]; end
                    endcase
                    r_lvl <= r_lvl - 3'd1;
                    r_nstart <= 1'b1;
                    r_state <= (r_lvl == 3'd1) ? S_VNORM : S_MID;
                end
                S_VNORM: if (w_done) begin
                    r_n[r_k[1:0]][0] <= w_ox; r_n[r_k[1:0]][1] <= w_oy;
                    r_n[r_k[1:0]][2] <= w_oz;
                    r_k <= r_k + 3'd1;
                    r_nstart <= (r_k != 3'd3);
                    if (r_k == 3'd3) begin
                        r_vi <= '0; r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_vi <= r_vi + 3'd1;
                    if (r_vi == 3'd5) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);
    assign o_pos_x = r_v[w_ei][0];
    assign o_pos_y = r_v[w_ei][1];
    assign o_pos_z = r_v[w_ei][2];
    assign o_norm_x = r_n[w_ei][0];
    assign o_norm_y = r_n[w_ei][1];
    assign o_norm_z = r_n[w_ei][2];
    assign o_tex_u = (w_ei == 2'd2) || (w_ei == 2'd3);
    assign o_tex_v = (w_ei == 2'd1) || (w_ei == 2'd2);
    assign o_last_vertex = o_valid && (r_vi == 3'd5);

    a_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_vertex |=> !o_valid) else $error("vertex after last");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("output while idle");
    a_lvl_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg <= CSQ_LVL_W'(MAX_LEVEL)) else $error("level above max");
endmodule
`default_nettype wire
